>>> sv/address_table_with_aging_assert.svh
// assertion macros for the address table with aging
`ifndef ADDRESS_TABLE_WITH_AGING_ASSERT_SVH
`define ADDRESS_TABLE_WITH_AGING_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds in the same cycle as the trigger
`define ATT_ASSERT_IMPLIES(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");
// condition holds in the cycle after the trigger
`define ATT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define ATT_ASSERT_IMPLIES(label, clk, rst_n, trig, cond)
`define ATT_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

>>> sv/att_pkg.sv
// shared types and codes of the address table with aging
package att_pkg;

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_PURGE  = 2'd1;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_PURGED    = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_READ
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] players;
    logic [15:0] limit;
    logic [15:0] proto;
    logic [31:0] seen;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    fetch;
    logic    hit_wr;
    logic    app_wr;
    logic    keep;
    logic    purge_end;
    logic    emit;
    status_e code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_upsert;
    logic is_purge;
    logic chk_end;
    logic key_match;
    logic survive;
    logic idx_ok;
    logic room;
    logic out_busy;
  } sts_t;

endpackage

>>> sv/att_dp.sv
// datapath of the address table: entry memory, pointers, result register
`include "address_table_with_aging_assert.svh"

module att_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [31:0]        cfg_wr_data_i,
  input  att_pkg::cmd_t      cmd_i,
  output att_pkg::sts_t      sts_o,
  input  logic [1:0]         op_i,
  input  logic [2:0]         addr_kind_i,
  input  logic [31:0]        ip_address_i,
  input  logic [15:0]        port_number_i,
  input  logic [15:0]        player_count_i,
  input  logic [15:0]        player_limit_i,
  input  logic [15:0]        proto_version_i,
  input  logic [31:0]        now_ms_i,
  input  logic [5:0]         read_index_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output att_pkg::status_e   status_o,
  output logic [6:0]         entry_count_o,
  output att_pkg::entry_t    out_entry_o
);
  import att_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RI_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [CNT_W-1:0] TABLE_MAX = CNT_W'(TABLE_ENTRIES);

  entry_t             mem_q [TABLE_ENTRIES];
  entry_t             rdata_q;
  entry_t             item_q;
  logic [1:0]         op_q;
  logic [5:0]         ridx_q;
  logic [31:0]        limit_q;
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic [CNT_W-1:0]   ptr_q, chk_q, kept_q;
  logic               out_valid_q;
  status_e            status_q;
  logic [6:0]         count_q;
  entry_t             res_q;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [31:0]        age;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      ridx_q <= read_index_i;
      item_q <= '{kind: addr_kind_i, ip: ip_address_i, port: port_number_i,
                  players: player_count_i, limit: player_limit_i,
                  proto: proto_version_i, seen: now_ms_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 32'd10000;
    end else if (cfg_wr_en_i) begin
      limit_q <= cfg_wr_data_i;
    end
  end

  // walk pointers: ptr is the next read address, chk the entry in rdata
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      chk_q  <= '0;
      kept_q <= '0;
    end else if (cmd_i.load) begin
      ptr_q  <= (op_i[1]) ? CNT_W'(read_index_i) : '0;
      chk_q  <= '0;
      kept_q <= '0;
    end else begin
      if (cmd_i.fetch) begin
        ptr_q <= ptr_q + 1'b1;
        chk_q <= ptr_q;
      end
      if (cmd_i.keep) begin
        kept_q <= kept_q + 1'b1;
      end
    end
  end

  always_comb begin
    filled_d = filled_q;
    if (cmd_i.app_wr) begin
      filled_d = filled_q + 1'b1;
    end else if (cmd_i.purge_end) begin
      filled_d = kept_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  // single write port
  always_comb begin
    mem_we    = cmd_i.hit_wr | cmd_i.app_wr | cmd_i.keep;
    mem_waddr = chk_q[IDX_W-1:0];
    mem_wdata = item_q;
    if (cmd_i.app_wr) begin
      mem_waddr = filled_q[IDX_W-1:0];
    end else if (cmd_i.keep) begin
      mem_waddr = kept_q[IDX_W-1:0];
      mem_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      rdata_q <= mem_q[ptr_q[IDX_W-1:0]];
    end
  end

  // status toward the controller
  assign age = item_q.seen - rdata_q.seen;

  always_comb begin
    sts_o.is_upsert = (op_q == OP_UPSERT);
    sts_o.is_purge  = (op_q == OP_PURGE);
    sts_o.chk_end   = (chk_q >= filled_q);
    sts_o.key_match = (rdata_q.kind == item_q.kind) && (rdata_q.ip == item_q.ip) &&
                      (rdata_q.port == item_q.port);
    sts_o.survive   = (age <= limit_q);
    sts_o.idx_ok    = (RI_W'(ridx_q) < RI_W'(filled_q));
    sts_o.room      = (filled_q < TABLE_MAX);
    sts_o.out_busy  = out_valid_q & out_stall_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.code;
      count_q  <= 7'(filled_d);
      res_q    <= (cmd_i.code == ST_READ_OK) ? rdata_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign out_entry_o   = res_q;

  `ATT_ASSERT_IMPLIES(a_fill_range, clk_i, rst_ni, 1'b1, filled_q <= TABLE_MAX)
  `ATT_ASSERT_IMPLIES(a_one_write, clk_i, rst_ni, 1'b1, $onehot0({cmd_i.hit_wr, cmd_i.app_wr, cmd_i.keep}))
  `ATT_ASSERT_IMPLIES(a_kept_behind, clk_i, rst_ni, cmd_i.keep, kept_q <= chk_q)

endmodule

>>> sv/att_ctrl.sv
// controller state machine of the address table
`include "address_table_with_aging_assert.svh"

module att_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  att_pkg::sts_t sts_i,
  output att_pkg::cmd_t cmd_o
);
  import att_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = (sts_i.is_upsert || sts_i.is_purge) ? S_SCAN : S_READ;
      end
      S_SCAN: begin
        if ((sts_i.chk_end || (sts_i.is_upsert && sts_i.key_match)) && !sts_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.code = ST_UPDATED;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      S_SCAN: begin
        if (sts_i.chk_end) begin
          if (!sts_i.out_busy) begin
            cmd_o.emit = 1'b1;
            if (sts_i.is_purge) begin
              cmd_o.purge_end = 1'b1;
              cmd_o.code      = ST_PURGED;
            end else if (sts_i.room) begin
              cmd_o.app_wr = 1'b1;
              cmd_o.code   = ST_INSERTED;
            end else begin
              cmd_o.code = ST_FULL;
            end
          end
        end else if (sts_i.is_upsert && sts_i.key_match) begin
          if (!sts_i.out_busy) begin
            cmd_o.emit   = 1'b1;
            cmd_o.hit_wr = 1'b1;
            cmd_o.code   = ST_UPDATED;
          end
        end else begin
          cmd_o.fetch = 1'b1;
          cmd_o.keep  = sts_i.is_purge & sts_i.survive;
        end
      end
      S_READ: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = sts_i.idx_ok ? ST_READ_OK : ST_BAD_INDEX;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  `ATT_ASSERT_IMPLIES(a_emit_free, clk_i, rst_ni, cmd_o.emit, !sts_i.out_busy)
  `ATT_ASSERT_NEXT(a_emit_idle, clk_i, rst_ni, cmd_o.emit, state_q == S_IDLE)

endmodule

>>> sv/address_table_with_aging.sv
// address table with aging: upsert, purge with compaction and indexed read
// an item is captured while idle and its first entry fetched; an upsert or purge then
// walks the filled entries, one entry per memory cycle, an upsert stopping at a key hit;
// the result is registered once the output is free, and the next item is taken after that
// reset clears the fill count and loads the expiry limit with 10000 ms;
// the entry memory is not cleared, only entries below the fill count are read
module address_table_with_aging #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: expiry limit in ms
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  addr_kind_i,
  input  logic [31:0] ip_address_i,
  input  logic [15:0] port_number_i,
  input  logic [15:0] player_count_i,
  input  logic [15:0] player_limit_i,
  input  logic [15:0] proto_version_i,
  input  logic [31:0] now_ms_i,
  input  logic [5:0]  read_index_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [6:0]  entry_count_o,
  output logic [2:0]  out_kind_o,
  output logic [31:0] out_ip_o,
  output logic [15:0] out_port_o,
  output logic [15:0] out_players_o,
  output logic [15:0] out_player_limit_o,
  output logic [15:0] out_proto_o,
  output logic [31:0] out_last_seen_o
);
  import att_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_e status;
  entry_t  res;

  // sequencer: idle, fetch first entry, walk, or single read
  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry memory, walk pointers, fill count and result register
  att_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .addr_kind_i     (addr_kind_i),
    .ip_address_i    (ip_address_i),
    .port_number_i   (port_number_i),
    .player_count_i  (player_count_i),
    .player_limit_i  (player_limit_i),
    .proto_version_i (proto_version_i),
    .now_ms_i        (now_ms_i),
    .read_index_i    (read_index_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status),
    .entry_count_o   (entry_count_o),
    .out_entry_o     (res)
  );

  // unpack the read entry onto the result ports
  assign status_o           = status;
  assign out_kind_o         = res.kind;
  assign out_ip_o           = res.ip;
  assign out_port_o         = res.port;
  assign out_players_o      = res.players;
  assign out_player_limit_o = res.limit;
  assign out_proto_o        = res.proto;
  assign out_last_seen_o    = res.seen;

endmodule
